// ===== hdl/sto_pkg.sv =====
// shared constants, types and helpers of the stochastic oscillator
`timescale 1ns / 1ps

package sto_pkg;

    // field widths
    localparam int PRICE_W    = 32;
    localparam int K_W        = 15;
    localparam int CFG_W      = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd14;

    // price store geometry
    localparam int WINDOW_MAX = 64;
    localparam int ADDR_W     = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

    // %K scaling: 100 * 256 = 2^14 + 2^13 + 2^10
    localparam int K_SH_A     = 14;
    localparam int K_SH_B     = 13;
    localparam int K_SH_C     = 10;
    localparam int NUM_W      = PRICE_W + K_W;
    localparam logic [K_W-1:0] K_MAX = 15'd25600;

    // %D: sum of three %K, divided by 3 through a reciprocal
    localparam int SUM_W      = K_W + 2;
    localparam int RECIP_W    = SUM_W - 1;
    localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'((2 ** SUM_W + 1) / 3);
    localparam int PROD_W     = SUM_W + RECIP_W;

    // divider step counter
    localparam int DCNT_W     = $clog2(K_W + 1);

    typedef logic [PRICE_W-1:0] t_price;
    typedef logic [K_W-1:0]     t_kval;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [CNT_W-1:0]   t_cnt;

    // window store command and response
    typedef struct packed {
        logic   wr;
        logic   walk;
        t_price price;
        t_cnt   len;
    } t_win_cmd;

    typedef struct packed {
        logic   done;
        t_price hi;
        t_price lo;
    } t_win_rsp;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        t_price           den;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_kval quot;
    } t_div_rsp;

    // one result item
    typedef struct packed {
        t_kval k_value;
        t_kval d_value;
        logic  window_full;
        logic  flat_window;
    } t_result;

    // circular pointer steps
    function automatic t_addr ptr_inc(input t_addr p);
        return (p == ADDR_W'(WINDOW_MAX - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic t_addr ptr_dec(input t_addr p);
        return (p == '0) ? ADDR_W'(WINDOW_MAX - 1) : p - 1'b1;
    endfunction

    // zero reads as one, large values clamp to the store depth
    function automatic t_cnt eff_len(input logic [CFG_W-1:0] cfg);
        if (cfg == '0) begin
            return t_cnt'(1);
        end
        if (int'(cfg) > WINDOW_MAX) begin
            return CNT_W'(WINDOW_MAX);
        end
        return CNT_W'(cfg);
    endfunction

endpackage

// ===== hdl/sto_in_if.sv =====
// input item channel: price sample and restart flag
`timescale 1ns / 1ps

interface sto_in_if;
    import sto_pkg::*;

    logic   valid;
    logic   ready;
    t_price price;
    logic   restart;

    modport source (output valid, price, restart, input ready);
    modport sink   (input valid, price, restart, output ready);
endinterface

// ===== hdl/sto_out_if.sv =====
// result item channel: %K, %D and status flags
`timescale 1ns / 1ps

interface sto_out_if;
    import sto_pkg::*;

    logic  valid;
    logic  ready;
    t_kval k_value;
    t_kval d_value;
    logic  window_full;
    logic  flat_window;

    modport source (output valid, k_value, d_value, window_full, flat_window, input ready);
    modport sink   (input valid, k_value, d_value, window_full, flat_window, output ready);
endinterface

// ===== hdl/sto_window.sv =====
// circular price store with a serial high/low walk over the newest entries
`timescale 1ns / 1ps

module sto_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sto_pkg::t_win_cmd i_cmd,
    output sto_pkg::t_win_rsp o_rsp
);
    import sto_pkg::*;

    t_price r_mem [WINDOW_MAX];
    t_price r_q;
    t_addr  r_wpos;
    t_addr  r_rd_ptr;
    t_cnt   r_left;
    logic   r_rd_vld;
    logic   r_busy;
    logic   r_done;
    t_price r_hi;
    t_price r_lo;
    logic   rd_en;

    // one read per cycle while entries remain
    assign rd_en = r_busy && (r_left != '0);

    // price memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[r_wpos] <= i_cmd.price;
        end
        if (rd_en) begin
            r_q <= r_mem[r_rd_ptr];
        end
    end

    // write pointer and walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos   <= '0;
            r_busy   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
            r_left   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.wr) begin
                r_wpos <= ptr_inc(r_wpos);
            end
            if (i_cmd.walk) begin
                // newest sample seeds high and low, older ones follow
                r_busy   <= 1'b1;
                r_rd_vld <= 1'b0;
                r_rd_ptr <= ptr_dec(r_wpos);
                r_left   <= i_cmd.len - 1'b1;
                r_hi     <= i_cmd.price;
                r_lo     <= i_cmd.price;
            end else if (r_busy) begin
                if (r_rd_vld) begin
                    if (r_q > r_hi) begin
                        r_hi <= r_q;
                    end
                    if (r_q < r_lo) begin
                        r_lo <= r_q;
                    end
                end
                if (rd_en) begin
                    r_rd_ptr <= ptr_dec(r_rd_ptr);
                    r_left   <= r_left - 1'b1;
                    r_rd_vld <= 1'b1;
                end else begin
                    r_rd_vld <= 1'b0;
                end
                if (!rd_en && !r_rd_vld) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hi   = r_hi;
    assign o_rsp.lo   = r_lo;

endmodule

// ===== hdl/sto_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module sto_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sto_pkg::t_div_req i_req,
    output sto_pkg::t_div_rsp o_rsp
);
    import sto_pkg::*;

    t_price              r_rem;
    t_price              r_den;
    logic [K_W-1:0]      r_nlo;
    t_kval               r_quot;
    logic [DCNT_W-1:0]   r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [PRICE_W:0]    trial;
    logic [PRICE_W:0]    diff;
    logic                ge;

    // shift in the next numerator bit and try a subtract
    assign trial = {r_rem, r_nlo[K_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                // quotient fits in K_W bits, so the upper part is below the divisor
                r_rem  <= i_req.num[NUM_W-1:K_W];
                r_nlo  <= i_req.num[K_W-1:0];
                r_den  <= i_req.den;
                r_quot <= '0;
                r_cnt  <= DCNT_W'(K_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= ge ? diff[PRICE_W-1:0] : trial[PRICE_W-1:0];
                r_nlo  <= {r_nlo[K_W-2:0], 1'b0};
                r_quot <= {r_quot[K_W-2:0], ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ===== hdl/stochastic_oscillator_core.sv =====
// stochastic oscillator top level: sequencing, %D averaging and result register
//
// channel   dir  handshake      payload
// i_in      in   valid/ready    price[31:0], restart
// o_out     out  valid/ready    k_value[14:0], d_value[14:0], window_full, flat_window
// i_cfg     in   write enable   i_cfg_wdata[6:0] = window length
//
// one item at a time; the next item can be accepted in the cycle after the result load
// window not yet full: straight to the result load; full: walk, multiply, divide, sum, load
// the walk reads one older price per cycle from the single read port, then 15 divider steps
// flat window skips multiply and divide; %D averaging adds a reciprocal step after the sum
// reset clears counts and %K history; the price memory is not cleared
// a held result does not block the next item; only the final load waits for o_out.ready
`timescale 1ns / 1ps

module stochastic_oscillator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sto_pkg::CFG_W-1:0]   i_cfg_wdata,
    sto_in_if.sink                      i_in,
    sto_out_if.source                   o_out
);
    import sto_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_MUL,
        S_DIV,
        S_SUM,
        S_RECIP,
        S_OUT
    } t_state;

    t_state              r_state,   n_state;
    logic [CFG_W-1:0]    r_cfg,     n_cfg;
    t_cnt                r_samples, n_samples;
    logic [1:0]          r_kcnt,    n_kcnt;
    t_kval               r_hist0,   n_hist0;
    t_kval               r_hist1,   n_hist1;
    t_price              r_price,   n_price;
    t_price              r_diff,    n_diff;
    t_price              r_den,     n_den;
    t_kval               r_k,       n_k;
    t_kval               r_d,       n_d;
    logic [SUM_W-1:0]    r_sum,     n_sum;
    logic                r_full,    n_full;
    logic                r_flat,    n_flat;
    logic                r_out_vld, n_out_vld;
    t_result             r_out,     n_out;

    t_win_cmd            win_cmd;
    t_win_rsp            win_rsp;
    t_div_req            div_req;
    t_div_rsp            div_rsp;
    logic                in_acc;
    t_cnt                len;
    t_cnt                base_cnt;
    t_cnt                new_cnt;
    logic [PROD_W-1:0]   prod;

    sto_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (win_cmd),
        .o_rsp   (win_rsp)
    );

    sto_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // handshake and sample count after this item
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign len        = eff_len(r_cfg);
    assign base_cnt   = i_in.restart ? '0 : r_samples;
    assign new_cnt    = (base_cnt < CNT_W'(WINDOW_MAX)) ? base_cnt + 1'b1 : base_cnt;

    // window store command
    assign win_cmd.wr    = in_acc;
    assign win_cmd.walk  = in_acc && (new_cnt >= len);
    assign win_cmd.price = i_in.price;
    assign win_cmd.len   = len;

    // divider load: (price - low) * 25600 by shift-add
    assign div_req.start = (r_state == S_MUL);
    assign div_req.num   = (NUM_W'(r_diff) << K_SH_A) + (NUM_W'(r_diff) << K_SH_B)
                         + (NUM_W'(r_diff) << K_SH_C);
    assign div_req.den   = r_den;

    // sum of three %K times the reciprocal of 3
    assign prod = PROD_W'(r_sum) * PROD_W'(RECIP3);

    // next state and data
    always_comb begin
        n_state   = r_state;
        n_cfg     = i_cfg_we ? i_cfg_wdata : r_cfg;
        n_samples = r_samples;
        n_kcnt    = r_kcnt;
        n_hist0   = r_hist0;
        n_hist1   = r_hist1;
        n_price   = r_price;
        n_diff    = r_diff;
        n_den     = r_den;
        n_k       = r_k;
        n_d       = r_d;
        n_sum     = r_sum;
        n_full    = r_full;
        n_flat    = r_flat;
        n_out_vld = (r_out_vld && o_out.ready) ? 1'b0 : r_out_vld;
        n_out     = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_samples = new_cnt;
                    n_price   = i_in.price;
                    n_flat    = 1'b0;
                    n_k       = '0;
                    n_d       = '0;
                    if (i_in.restart) begin
                        n_kcnt  = '0;
                        n_hist0 = '0;
                        n_hist1 = '0;
                    end
                    if (new_cnt >= len) begin
                        n_full  = 1'b1;
                        n_state = S_WALK;
                    end else begin
                        n_full  = 1'b0;
                        n_state = S_OUT;
                    end
                end
            end
            S_WALK: begin
                if (win_rsp.done) begin
                    if (win_rsp.hi == win_rsp.lo) begin
                        n_flat  = 1'b1;
                        n_k     = '0;
                        n_state = S_SUM;
                    end else begin
                        n_diff  = r_price - win_rsp.lo;
                        n_den   = win_rsp.hi - win_rsp.lo;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_k     = div_rsp.quot;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                // %D needs two earlier %K values in this series
                n_sum   = SUM_W'(r_k) + SUM_W'(r_hist0) + SUM_W'(r_hist1);
                n_hist1 = r_hist0;
                n_hist0 = r_k;
                if (r_kcnt == 2'd2) begin
                    n_state = S_RECIP;
                end else begin
                    n_kcnt  = r_kcnt + 1'b1;
                    n_d     = r_k;
                    n_state = S_OUT;
                end
            end
            S_RECIP: begin
                n_d     = prod[SUM_W +: K_W];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld         = 1'b1;
                    n_out.k_value     = r_k;
                    n_out.d_value     = r_d;
                    n_out.window_full = r_full;
                    n_out.flat_window = r_flat;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= CFG_RESET;
            r_samples <= '0;
            r_kcnt    <= '0;
            r_hist0   <= '0;
            r_hist1   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cfg     <= n_cfg;
            r_samples <= n_samples;
            r_kcnt    <= n_kcnt;
            r_hist0   <= n_hist0;
            r_hist1   <= n_hist1;
            r_price   <= n_price;
            r_diff    <= n_diff;
            r_den     <= n_den;
            r_k       <= n_k;
            r_d       <= n_d;
            r_sum     <= n_sum;
            r_full    <= n_full;
            r_flat    <= n_flat;
            r_out_vld <= n_out_vld;
            r_out     <= n_out;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.k_value     = r_out.k_value;
    assign o_out.d_value     = r_out.d_value;
    assign o_out.window_full = r_out.window_full;
    assign o_out.flat_window = r_out.flat_window;

    // a partial window reports nothing but zeros
    a_not_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.window_full) |->
            (o_out.k_value == '0 && o_out.d_value == '0 && !o_out.flat_window))
        else $error("partial window item carries nonzero fields");

    // a flat window forces %K to zero
    a_flat_k_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.flat_window) |-> (o_out.k_value == '0))
        else $error("flat window with nonzero %%K");

    // %K and %D stay within 0..100.0
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.k_value <= K_MAX && o_out.d_value <= K_MAX))
        else $error("%%K or %%D above full scale");

    // one item in flight: no new item the cycle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("input ready right after an accepted item");

endmodule
